### sv/ccfn_pkg.sv
// ---------------------------------------------------------------------------
// ccfn_pkg
// Shared constants for the cache candidate feature normaliser: feature
// indices, fixed means and deviations, reciprocals and pipeline depths.
// ---------------------------------------------------------------------------
package ccfn_pkg;

   localparam int unsigned NUM_FEATURES = 6;
   localparam int unsigned OUT_W        = 16;
   localparam int unsigned MASK_W       = 6;

   localparam int unsigned FEAT_AGE  = 0;
   localparam int unsigned FEAT_SIZE = 1;
   localparam int unsigned FEAT_HITS = 2;
   localparam int unsigned FEAT_IDLE = 3;
   localparam int unsigned FEAT_TTL  = 4;
   localparam int unsigned FEAT_RTT  = 5;

   localparam logic [MASK_W-1:0] MASK_RESET = 6'd63;

   localparam logic [9:0] FEAT_MEAN [NUM_FEATURES] =
      '{10'd300, 10'd50, 10'd5, 10'd60, 10'd600, 10'd150};
   localparam logic [7:0] FEAT_DEV [NUM_FEATURES] =
      '{8'd100, 8'd100, 8'd10, 8'd30, 8'd200, 8'd50};
   localparam logic [31:0] DEV_RECIP [NUM_FEATURES] = '{
      32'((64'd1 << 32) / 64'd100),
      32'((64'd1 << 32) / 64'd100),
      32'((64'd1 << 32) / 64'd10),
      32'((64'd1 << 32) / 64'd30),
      32'((64'd1 << 32) / 64'd200),
      32'((64'd1 << 32) / 64'd50)
   };

   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [10:0] SIZE_BIAS  = 11'd1024;
   localparam logic [6:0]  SIZE_MEAN  = 7'd50;
   localparam logic [3:0]  SAT_MULT   = 4'd6;
   localparam logic [3:0]  CLIP_MULT  = 4'd5;

   localparam int unsigned LOG_SQ_STEPS = 32;
   localparam int unsigned LOG_LATENCY  = LOG_SQ_STEPS + 4;
   localparam int unsigned OUT_LATENCY  = LOG_LATENCY + 4;

endpackage

### sv/cache_candidate_feature_normalizer.sv
// ---------------------------------------------------------------------------
// cache_candidate_feature_normalizer
// Z-score normalisation with clipping of six cache eviction candidate
// features, one candidate per clock.
// ---------------------------------------------------------------------------
// The block takes one candidate item in every clock cycle and never raises
// busy. Each result row appears on the rsp_ ports for one cycle with
// rsp_valid high; rows leave in the order their items came in. The depth is
// set by the size feature, whose base-two logarithm is built one fraction bit
// per pipeline stage over 32 squaring stages, followed by the ln 2 scaling,
// a division by constant in stages d1 and d2 and a clip in stage rsp. The
// receiver cannot stall the block, so it must take every row in the cycle in
// which it is shown. The feature enable mask should only be written while no
// item is in flight.
// ---------------------------------------------------------------------------
module cache_candidate_feature_normalizer #(
   parameter int unsigned OUT_FRAC_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [31:0]        req_now_seconds,
   input  logic [31:0]        req_created_seconds,
   input  logic [31:0]        req_last_access_seconds,
   input  logic [39:0]        req_size_bytes,
   input  logic [31:0]        req_hit_count,
   input  logic signed [31:0] req_ttl_left_seconds,
   input  logic [31:0]        req_origin_rtt_us,
   input  logic               req_last_in_batch,
   input  logic               csr_write_en,
   input  logic [5:0]         csr_write_data,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_norm_age,
   output logic signed [15:0] rsp_norm_size,
   output logic signed [15:0] rsp_norm_hits,
   output logic signed [15:0] rsp_norm_idle_time,
   output logic signed [15:0] rsp_norm_ttl,
   output logic signed [15:0] rsp_norm_rtt,
   output logic               rsp_last_row
);
   import ccfn_pkg::*;

   localparam int unsigned NUM_W  = OUT_FRAC_BITS + 12;
   localparam int unsigned PROD_W = NUM_W + 32;
   localparam int unsigned DIFF_W = 34;

   typedef struct packed {
      logic             neg;
      logic             sat;
      logic [NUM_W-1:0] num;
   } lane_type;

   localparam logic [NUM_W-1:0] CLIP_LIM = NUM_W'(CLIP_MULT) << OUT_FRAC_BITS;

   logic [MASK_W-1:0] mask_ff;

   logic        in_vld_ff;
   logic        in_last_ff;
   logic [31:0] in_now_ff, in_created_ff, in_last_acc_ff, in_hits_ff, in_rtt_ff;
   logic [31:0] in_ttl_ff;
   logic [39:0] in_size_ff;

   logic signed [DIFF_W-1:0] raw      [NUM_FEATURES];
   logic signed [DIFF_W-1:0] centred  [NUM_FEATURES];
   logic [DIFF_W-1:0]        mag      [NUM_FEATURES];
   lane_type                 lane_in  [NUM_FEATURES];

   logic [LOG_LATENCY-1:0]   vld_dly_ff;
   logic [LOG_LATENCY-1:0]   last_dly_ff;
   lane_type                 lane_dly_ff [LOG_LATENCY][NUM_FEATURES];

   logic [NUM_W-1:0]         log_num;
   logic                     log_neg;

   lane_type                 div_in   [NUM_FEATURES];
   logic [PROD_W-1:0]        q0_prod  [NUM_FEATURES];
   logic [NUM_W-1:0]         rem      [NUM_FEATURES];
   logic [NUM_W-1:0]         q_in     [NUM_FEATURES];
   logic [NUM_W-1:0]         clip_q   [NUM_FEATURES];
   logic [NUM_W-1:0]         signed_q [NUM_FEATURES];
   logic [OUT_W-1:0]         feat_in  [NUM_FEATURES];

   lane_type                 d1_lane_ff [NUM_FEATURES];
   logic [NUM_W-1:0]         d1_q0_ff   [NUM_FEATURES];
   logic                     d1_vld_ff, d1_last_ff;
   logic [NUM_W-1:0]         d2_q_ff    [NUM_FEATURES];
   logic                     d2_neg_ff  [NUM_FEATURES];
   logic                     d2_sat_ff  [NUM_FEATURES];
   logic                     d2_vld_ff, d2_last_ff;
   logic [OUT_W-1:0]         rsp_feat_ff [NUM_FEATURES];
   logic                     rsp_vld_ff, rsp_last_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_write_en) begin
         mask_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      in_now_ff      <= req_now_seconds;
      in_created_ff  <= req_created_seconds;
      in_last_acc_ff <= req_last_access_seconds;
      in_size_ff     <= req_size_bytes;
      in_hits_ff     <= req_hit_count;
      in_ttl_ff      <= req_ttl_left_seconds;
      in_rtt_ff      <= req_origin_rtt_us;
      in_last_ff     <= req_last_in_batch;
   end

   always_comb begin
      raw[FEAT_AGE]  = $signed(DIFF_W'(in_now_ff)) - $signed(DIFF_W'(in_created_ff));
      raw[FEAT_SIZE] = '0;
      raw[FEAT_HITS] = $signed(DIFF_W'(in_hits_ff));
      raw[FEAT_IDLE] = $signed(DIFF_W'(in_now_ff)) - $signed(DIFF_W'(in_last_acc_ff));
      raw[FEAT_TTL]  = DIFF_W'($signed(in_ttl_ff));
      raw[FEAT_RTT]  = $signed(DIFF_W'(in_rtt_ff));
      for (int j = 0; j < NUM_FEATURES; j++) begin
         centred[j]     = raw[j] - $signed(DIFF_W'(FEAT_MEAN[j]));
         lane_in[j].neg = centred[j][DIFF_W-1];
         mag[j]         = lane_in[j].neg ? DIFF_W'(-centred[j]) : DIFF_W'(centred[j]);
         lane_in[j].sat = mag[j] > DIFF_W'(SAT_MULT * FEAT_DEV[j]);
         if (lane_in[j].sat || (j == FEAT_SIZE)) begin
            lane_in[j].num = '0;
         end else begin
            lane_in[j].num = (NUM_W'(mag[j]) << OUT_FRAC_BITS)
                           + NUM_W'(FEAT_DEV[j] >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_dly_ff <= '0;
      end else begin
         vld_dly_ff <= {vld_dly_ff[LOG_LATENCY-2:0], in_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      last_dly_ff    <= {last_dly_ff[LOG_LATENCY-2:0], in_last_ff};
      lane_dly_ff[0] <= lane_in;
      for (int k = 1; k < LOG_LATENCY; k++) begin
         lane_dly_ff[k] <= lane_dly_ff[k-1];
      end
   end

   ccfn_log_size #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .NUM_W         (NUM_W)
   ) u_log_size (
      .clock      (clock),
      .size_bytes (in_size_ff),
      .num_out    (log_num),
      .neg_out    (log_neg)
   );

   always_comb begin
      for (int j = 0; j < NUM_FEATURES; j++) begin
         if (j == FEAT_SIZE) begin
            div_in[j].neg = log_neg;
            div_in[j].sat = 1'b0;
            div_in[j].num = log_num;
         end else begin
            div_in[j] = lane_dly_ff[LOG_LATENCY-1][j];
         end
         q0_prod[j] = PROD_W'(div_in[j].num) * PROD_W'(DEV_RECIP[j]);
      end
   end

   always_ff @(posedge clock) begin
      d1_lane_ff <= div_in;
      for (int j = 0; j < NUM_FEATURES; j++) begin
         d1_q0_ff[j] <= q0_prod[j][PROD_W-1:32];
      end
      d1_last_ff <= last_dly_ff[LOG_LATENCY-1];
   end

   always_comb begin
      for (int j = 0; j < NUM_FEATURES; j++) begin
         rem[j]  = d1_lane_ff[j].num - d1_q0_ff[j] * NUM_W'(FEAT_DEV[j]);
         q_in[j] = d1_q0_ff[j] + NUM_W'(rem[j] >= NUM_W'(FEAT_DEV[j]));
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_FEATURES; j++) begin
         d2_q_ff[j]   <= q_in[j];
         d2_neg_ff[j] <= d1_lane_ff[j].neg;
         d2_sat_ff[j] <= d1_lane_ff[j].sat;
      end
      d2_last_ff <= d1_last_ff;
   end

   always_comb begin
      for (int j = 0; j < NUM_FEATURES; j++) begin
         clip_q[j]   = (d2_sat_ff[j] || (d2_q_ff[j] > CLIP_LIM)) ? CLIP_LIM : d2_q_ff[j];
         signed_q[j] = d2_neg_ff[j] ? (~clip_q[j] + NUM_W'(1)) : clip_q[j];
         feat_in[j]  = mask_ff[j] ? signed_q[j][OUT_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_feat_ff <= feat_in;
      rsp_last_ff <= d2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff  <= 1'b0;
         d2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         d1_vld_ff  <= vld_dly_ff[LOG_LATENCY-1];
         d2_vld_ff  <= d1_vld_ff;
         rsp_vld_ff <= d2_vld_ff;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_last_row       = rsp_last_ff;
   assign rsp_norm_age       = rsp_feat_ff[FEAT_AGE];
   assign rsp_norm_size      = rsp_feat_ff[FEAT_SIZE];
   assign rsp_norm_hits      = rsp_feat_ff[FEAT_HITS];
   assign rsp_norm_idle_time = rsp_feat_ff[FEAT_IDLE];
   assign rsp_norm_ttl       = rsp_feat_ff[FEAT_TTL];
   assign rsp_norm_rtt       = rsp_feat_ff[FEAT_RTT];

   // A result row can only leave for an item taken the full latency before.
   a_rsp_from_item : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, OUT_LATENCY))
      else $error("result row without a matching item");

   a_last_row_aligned : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_row == $past(req_last_in_batch, OUT_LATENCY)))
      else $error("last row flag out of step with its item");

   // The reciprocal estimate is never more than one below the true quotient.
   for (genvar j = 0; j < NUM_FEATURES; j++) begin : g_chk
      a_rem_bound : assert property (@(posedge clock) disable iff (reset)
         d1_vld_ff |-> (rem[j] < (NUM_W'(FEAT_DEV[j]) << 1)))
         else $error("division correction out of range");
   end

   a_log_bound : assert property (@(posedge clock) disable iff (reset)
      vld_dly_ff[LOG_LATENCY-1] |->
         (log_num <= ((NUM_W'(SIZE_MEAN) << OUT_FRAC_BITS) + NUM_W'(SIZE_MEAN))))
      else $error("log size numerator out of range");

endmodule

### sv/ccfn_log_size.sv
// ---------------------------------------------------------------------------
// ccfn_log_size
// Pipelined ln(1 + size/1024) for the size feature. Log2 is formed one
// fraction bit per stage by repeated squaring, scaled by ln 2 and turned
// into the rounding numerator for a division by the size deviation.
// ---------------------------------------------------------------------------
module ccfn_log_size #(
   parameter int unsigned OUT_FRAC_BITS = 12,
   parameter int unsigned NUM_W         = 24
) (
   input  logic             clock,
   input  logic [39:0]      size_bytes,
   output logic [NUM_W-1:0] num_out,
   output logic             neg_out
);
   import ccfn_pkg::*;

   localparam int unsigned XW = 41;
   localparam int unsigned EW = 6;
   localparam int unsigned DW = 39;

   logic [XW-1:0] x_in, x_ff;
   logic [EW-1:0] e_in, e_ff;
   logic [63:0]   mant_wide;
   logic [31:0]   mant_in;

   logic [31:0]   m_ff    [LOG_SQ_STEPS+1];
   logic [31:0]   frac_ff [LOG_SQ_STEPS+1];
   logic [EW-1:0] esq_ff  [LOG_SQ_STEPS+1];

   logic [30:0]   l2_sh;
   logic [62:0]   prod_in, prod_ff;
   logic [36:0]   ln_q32;
   logic [DW-1:0] diff, mag, mag_sh;
   logic [NUM_W-1:0] num_in, num_ff;
   logic          neg_in, neg_ff;

   always_comb begin
      x_in = XW'(size_bytes) + XW'(SIZE_BIAS);
      e_in = '0;
      for (int i = 0; i < XW; i++) begin
         if (x_in[i]) begin
            e_in = EW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      e_ff <= e_in;
   end

   always_comb begin
      if (e_ff > EW'(31)) begin
         mant_wide = 64'(x_ff >> (e_ff - EW'(31)));
      end else begin
         mant_wide = 64'(x_ff) << (EW'(31) - e_ff);
      end
      mant_in = mant_wide[31:0];
   end

   always_ff @(posedge clock) begin
      m_ff[0]    <= mant_in;
      frac_ff[0] <= '0;
      esq_ff[0]  <= e_ff;
   end

   for (genvar k = 1; k <= LOG_SQ_STEPS; k++) begin : g_sq
      logic [63:0] sq;
      logic        bit_one;
      logic [31:0] m_next;

      always_comb begin
         sq      = m_ff[k-1] * m_ff[k-1];
         bit_one = sq[63];
         m_next  = bit_one ? sq[63:32] : sq[62:31];
      end

      always_ff @(posedge clock) begin
         m_ff[k]    <= m_next;
         frac_ff[k] <= {frac_ff[k-1][30:0], bit_one};
         esq_ff[k]  <= esq_ff[k-1];
      end
   end

   always_comb begin
      l2_sh   = {5'(esq_ff[LOG_SQ_STEPS] - EW'(10)), frac_ff[LOG_SQ_STEPS][31:6]};
      prod_in = 63'(l2_sh) * 63'(LN2_Q32);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      ln_q32 = prod_ff[62:26];
      diff   = DW'(ln_q32) - (DW'(SIZE_MEAN) << 32);
      neg_in = diff[DW-1];
      mag    = neg_in ? (~diff + DW'(1)) : diff;
      mag_sh = mag >> (32 - OUT_FRAC_BITS);
      num_in = NUM_W'(mag_sh) + NUM_W'(SIZE_MEAN);
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      neg_ff <= neg_in;
   end

   assign num_out = num_ff;
   assign neg_out = neg_ff;

endmodule
